[rtl/core/pbwt_pkg.sv]
package pbwt_pkg;

  // fixed field widths
  localparam int unsigned AlleleW = 64;
  localparam int unsigned IdW     = 6;
  localparam int unsigned DivW    = 16;
  localparam int unsigned CfgW    = 7;
  localparam int unsigned OutDataW = 24;

  // reset value of the haplotype count register
  localparam logic [CfgW-1:0] CountReset = 7'd64;

  // one stored entry of the order and divergence stores
  typedef struct packed {
    logic [DivW-1:0] div;
    logic [IdW-1:0]  id;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  // one result beat waiting at the output
  typedef struct packed {
    logic   last;
    entry_t ent;
  } out_beat_t;

  // sequencer states
  typedef enum logic [1:0] {
    SeqIdle,
    SeqSweep,
    SeqSettle,
    SeqEmit
  } seq_state_e;

  // sequencer to datapath
  typedef struct packed {
    logic idle;
    logic sweep_issue;
    logic emit_issue;
  } seq_ctrl_t;

  // datapath to sequencer
  typedef struct packed {
    logic sweep_last;
    logic emit_last;
    logic can_issue;
  } seq_stat_t;

  // result of the shared max unit
  typedef struct packed {
    logic [DivW-1:0] zero_max;
    logic [DivW-1:0] one_max;
  } maxu_res_t;

endpackage

[rtl/core/pbwt_prefix_divergence_update_top.sv]
// PBWT column step over up to MAX_HAPLOTYPES haplotypes. Each input beat is
// one site (allele bits plus a restart flag in tuser); the block answers with
// one output beat per haplotype in the new prefix order, tlast on the final
// one. The order store has one read port and is swept one entry per cycle
// through a shared max unit, then the zero-side and one-side staging stores
// are read out one entry per cycle. Output stalls stretch the read-out phase.
// Results of a site may still wait in the two-beat output buffer while the
// next site is taken.
module pbwt_prefix_divergence_update_top import pbwt_pkg::*; #(
  parameter int unsigned      MAX_HAPLOTYPES = 64,
  parameter longint unsigned  MAX_SITES      = 65535
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration: haplotype count
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgW-1:0]     cfg_data_i,
  // site input
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [AlleleW-1:0]  s_axis_tdata,   // [63:0] allele_bits
  input  logic [0:0]          s_axis_tuser,   // [0] restart
  // result output
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // [5:0] haplotype_id, [21:6] divergence
  output logic                m_axis_tlast
);

  localparam int unsigned AW = $clog2(MAX_HAPLOTYPES);
  localparam int unsigned CW = AW + 1;
  localparam longint unsigned CapL = (MAX_SITES < 64'd65535) ? MAX_SITES : 64'd65535;
  localparam logic [DivW-1:0] SiteCap = DivW'(CapL);

  seq_ctrl_t ctrl;
  seq_stat_t stat;
  logic      in_accept;

  // configuration register
  logic [CfgW-1:0] cfg_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CountReset;
    end else if (cfg_valid_i) begin
      cfg_q <= cfg_data_i;
    end
  end

  // clamped haplotype count
  logic [CW-1:0] cnt_sel;
  always_comb begin
    priority if (cfg_q == '0) begin
      cnt_sel = CW'(1);
    end else if (cfg_q > CfgW'(MAX_HAPLOTYPES)) begin
      cnt_sel = CW'(MAX_HAPLOTYPES);
    end else begin
      cnt_sel = CW'(cfg_q);
    end
  end

  assign s_axis_tready = ctrl.idle;
  assign in_accept     = s_axis_tvalid & s_axis_tready;

  // saturating site count, restart starts over at site 0
  logic [DivW-1:0] site_q, site_eff, start_val;
  assign site_eff  = s_axis_tuser[0] ? '0 : site_q;
  assign start_val = (site_eff >= SiteCap) ? SiteCap : site_eff + DivW'(1);

  // per-site registers
  logic [AlleleW-1:0] allele_q;
  logic [CW-1:0]      cnt_q;
  logic [CW-1:0]      nz_q, no_q;
  logic [DivW-1:0]    zmax_q, omax_q;
  logic [AW-1:0]      rd_q, em_q;

  // sweep read stage
  logic          s1_valid_q, s1_hit_q;
  logic [AW-1:0] s1_idx_q;

  // read-out stage
  logic          pend_q, pend_zone_q, pend_last_q;
  logic [AW-1:0] pend_idx_q;

  // valid bits of the order store, invalid reads as identity and zero
  logic [MAX_HAPLOTYPES-1:0] vld_q;

  entry_t main_rd, z_rd, o_rd, cur, pend_ent;
  maxu_res_t mres;
  logic      cur_bit;
  logic      em_zone;
  logic [CW-1:0] em_ones;

  // current swept entry
  always_comb begin
    if (s1_hit_q) begin
      cur = main_rd;
    end else begin
      cur.id  = IdW'(s1_idx_q);
      cur.div = '0;
    end
  end
  assign cur_bit = allele_q[cur.id];

  pbwt_maxu u_maxu (
    .zero_max_i (zmax_q),
    .one_max_i  (omax_q),
    .div_i      (cur.div),
    .res_o      (mres)
  );

  // read-out address select
  assign em_zone = {1'b0, em_q} < nz_q;
  assign em_ones = {1'b0, em_q} - nz_q;
  assign pend_ent = pend_zone_q ? z_rd : o_rd;

  // output buffer occupancy and read-out credit
  logic      pop;
  logic [1:0] fifo_cnt_q, occ;
  logic      fifo_wr_q, fifo_rd_q;
  out_beat_t fifo_q [2];

  assign pop = m_axis_tvalid & m_axis_tready;
  assign occ = fifo_cnt_q + 2'(pend_q) - 2'(pop);

  assign stat.can_issue  = occ <= 2'd1;
  assign stat.sweep_last = {1'b0, rd_q} == (cnt_q - CW'(1));
  assign stat.emit_last  = {1'b0, em_q} == (cnt_q - CW'(1));

  pbwt_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_accept_i (in_accept),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  // order and divergence store
  pbwt_ram #(.Width(EntryW), .Depth(MAX_HAPLOTYPES)) u_main_ram (
    .clk_i   (clk_i),
    .we_i    (pend_q),
    .waddr_i (pend_idx_q),
    .wdata_i (pend_ent),
    .re_i    (ctrl.sweep_issue),
    .raddr_i (rd_q),
    .rdata_o (main_rd)
  );

  // zero-side staging
  pbwt_ram #(.Width(EntryW), .Depth(MAX_HAPLOTYPES)) u_zero_ram (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q & ~cur_bit),
    .waddr_i (nz_q[AW-1:0]),
    .wdata_i ({mres.zero_max, cur.id}),
    .re_i    (ctrl.emit_issue & em_zone),
    .raddr_i (em_q),
    .rdata_o (z_rd)
  );

  // one-side staging
  pbwt_ram #(.Width(EntryW), .Depth(MAX_HAPLOTYPES)) u_one_ram (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q & cur_bit),
    .waddr_i (no_q[AW-1:0]),
    .wdata_i ({mres.one_max, cur.id}),
    .re_i    (ctrl.emit_issue & ~em_zone),
    .raddr_i (em_ones[AW-1:0]),
    .rdata_o (o_rd)
  );

  // control registers of the sweep and read-out
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      site_q      <= '0;
      s1_valid_q  <= 1'b0;
      pend_q      <= 1'b0;
      vld_q       <= '0;
      rd_q        <= '0;
      em_q        <= '0;
      nz_q        <= '0;
      no_q        <= '0;
      cnt_q       <= CW'(1);
    end else begin
      s1_valid_q <= ctrl.sweep_issue;
      pend_q     <= ctrl.emit_issue;
      // restart drops every stored entry, else mark the one written back
      if (in_accept && s_axis_tuser[0]) begin
        vld_q <= '0;
      end else if (pend_q) begin
        vld_q[pend_idx_q] <= 1'b1;
      end
      if (in_accept) begin
        site_q <= start_val;
        cnt_q  <= cnt_sel;
        rd_q   <= '0;
        em_q   <= '0;
        nz_q   <= '0;
        no_q   <= '0;
      end
      if (ctrl.sweep_issue) begin
        rd_q <= rd_q + AW'(1);
      end
      if (ctrl.emit_issue) begin
        em_q <= em_q + AW'(1);
      end
      if (s1_valid_q) begin
        if (cur_bit) begin
          no_q <= no_q + CW'(1);
        end else begin
          nz_q <= nz_q + CW'(1);
        end
      end
    end
  end

  // payload registers of the sweep and read-out
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      allele_q <= s_axis_tdata;
      zmax_q   <= start_val;
      omax_q   <= start_val;
    end else if (s1_valid_q) begin
      zmax_q <= cur_bit ? mres.zero_max : '0;
      omax_q <= cur_bit ? '0 : mres.one_max;
    end
    if (ctrl.sweep_issue) begin
      s1_hit_q <= vld_q[rd_q];
      s1_idx_q <= rd_q;
    end
    if (ctrl.emit_issue) begin
      pend_zone_q <= em_zone;
      pend_last_q <= stat.emit_last;
      pend_idx_q  <= em_q;
    end
  end

  // two-beat output buffer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fifo_cnt_q <= '0;
      fifo_wr_q  <= 1'b0;
      fifo_rd_q  <= 1'b0;
    end else begin
      fifo_cnt_q <= fifo_cnt_q + 2'(pend_q) - 2'(pop);
      if (pend_q) fifo_wr_q <= ~fifo_wr_q;
      if (pop)    fifo_rd_q <= ~fifo_rd_q;
    end
  end

  // output buffer payload
  always_ff @(posedge clk_i) begin
    if (pend_q) begin
      fifo_q[fifo_wr_q] <= '{last: pend_last_q, ent: pend_ent};
    end
  end

  assign m_axis_tvalid = fifo_cnt_q != '0;
  assign m_axis_tdata  = {2'b00, fifo_q[fifo_rd_q].ent.div, fifo_q[fifo_rd_q].ent.id};
  assign m_axis_tlast  = fifo_q[fifo_rd_q].last;

endmodule

[rtl/core/pbwt_ram.sv]
module pbwt_ram #(
  parameter int unsigned Width = 22,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/pbwt_maxu.sv]
module pbwt_maxu import pbwt_pkg::*; (
  input  logic [DivW-1:0] zero_max_i,
  input  logic [DivW-1:0] one_max_i,
  input  logic [DivW-1:0] div_i,
  output maxu_res_t       res_o
);

  // both running maxima take in the divergence just read
  always_comb begin
    res_o.zero_max = (div_i > zero_max_i) ? div_i : zero_max_i;
    res_o.one_max  = (div_i > one_max_i) ? div_i : one_max_i;
  end

endmodule

[rtl/core/pbwt_seq.sv]
module pbwt_seq import pbwt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_accept_i,
  input  seq_stat_t stat_i,
  output seq_ctrl_t ctrl_o
);

  seq_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SeqIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SeqIdle: begin
        if (in_accept_i) state_d = SeqSweep;
      end
      SeqSweep: begin
        if (stat_i.sweep_last) state_d = SeqSettle;
      end
      SeqSettle: begin
        state_d = SeqEmit;
      end
      SeqEmit: begin
        if (stat_i.can_issue && stat_i.emit_last) state_d = SeqIdle;
      end
      default: begin
        state_d = SeqIdle;
      end
    endcase
  end

  // outputs
  always_comb begin
    ctrl_o = '0;
    unique case (state_q)
      SeqIdle:   ctrl_o.idle = 1'b1;
      SeqSweep:  ctrl_o.sweep_issue = 1'b1;
      SeqSettle: ctrl_o = '0;
      SeqEmit:   ctrl_o.emit_issue = stat_i.can_issue;
      default:   ctrl_o = '0;
    endcase
  end

endmodule

[rtl/core/pbwt_chk.sv]
module pbwt_chk import pbwt_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                cfg_valid_i,
  input logic                cfg_ready_o,
  input logic [CfgW-1:0]     cfg_data_i,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic [AlleleW-1:0]  s_axis_tdata,
  input logic [0:0]          s_axis_tuser,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic                m_axis_tlast
);

  // a stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("stalled result beat changed");

  // the block is busy right after taking a site
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("site taken while sweep in progress");

  // padding bits of a result stay zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[OutDataW-1:22] == '0)
    else $error("result padding not zero");

  // the configuration port never back-pressures
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write stalled");

endmodule

bind pbwt_prefix_divergence_update_top pbwt_chk u_pbwt_chk (.*);
